// ===== rtl/hdp_pkg.sv =====
// ----------------------------------------------------------------------------
// hdp_pkg
// Types, constants and name tables shared by the HTTP date parser modules.
// ----------------------------------------------------------------------------
package hdp_pkg;

  localparam int unsigned NUM_OPS   = 24;
  localparam int unsigned PH_W      = 5;
  localparam int unsigned NUM_DAYS  = 14;
  localparam int unsigned NUM_MONS  = 12;
  localparam logic [16:0] NUM_SAT   = 17'h1FFFF;

  localparam logic [7:0]  CH_COLON  = 8'h3A;
  localparam logic [7:0]  CH_COMMA  = 8'h2C;
  localparam logic [7:0]  CH_DASH   = 8'h2D;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_TAB    = 8'h09;

  localparam logic [1:0]  FMT_RFC1123 = 2'd0;
  localparam logic [1:0]  FMT_RFC850  = 2'd1;
  localparam logic [1:0]  FMT_ASCTIME = 2'd2;

  localparam logic [7:0]  D_DAY  = 8'd0;
  localparam logic [7:0]  D_YEAR = 8'd1;
  localparam logic [7:0]  D_Y850 = 8'd2;
  localparam logic [7:0]  D_HOUR = 8'd3;
  localparam logic [7:0]  D_MIN  = 8'd4;
  localparam logic [7:0]  D_SEC  = 8'd5;

  typedef enum logic [2:0] {
    K_END, K_BLANKS, K_SKIP, K_CHAR, K_NUM, K_MONTH, K_GMT
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [7:0] arg;
  } op_t;

  // parsed fields of one complete string, handed to the epoch unit
  typedef struct packed {
    logic        err;
    logic [1:0]  fmt;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] sod;
  } date_rec_t;

  function automatic op_t mk(op_kind_e k, logic [7:0] a);
    op_t o;
    o.kind = k;
    o.arg  = a;
    return o;
  endfunction

  function automatic op_t op_rfc1123(logic [4:0] i);
    op_t o;
    case (i)
      5'd1:    o = mk(K_NUM, D_DAY);
      5'd3:    o = mk(K_MONTH, 8'd0);
      5'd5:    o = mk(K_NUM, D_YEAR);
      5'd7:    o = mk(K_NUM, D_HOUR);
      5'd9:    o = mk(K_CHAR, CH_COLON);
      5'd11:   o = mk(K_NUM, D_MIN);
      5'd13:   o = mk(K_CHAR, CH_COLON);
      5'd15:   o = mk(K_NUM, D_SEC);
      5'd17:   o = mk(K_GMT, 8'd0);
      5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16:
               o = mk(K_BLANKS, 8'd0);
      default: o = mk(K_END, 8'd0);
    endcase
    return o;
  endfunction

  function automatic op_t op_rfc850(logic [4:0] i);
    op_t o;
    case (i)
      5'd1:    o = mk(K_CHAR, CH_COMMA);
      5'd3:    o = mk(K_NUM, D_DAY);
      5'd4:    o = mk(K_CHAR, CH_DASH);
      5'd5:    o = mk(K_MONTH, 8'd0);
      5'd6:    o = mk(K_CHAR, CH_DASH);
      5'd7:    o = mk(K_NUM, D_Y850);
      5'd9:    o = mk(K_NUM, D_HOUR);
      5'd11:   o = mk(K_CHAR, CH_COLON);
      5'd13:   o = mk(K_NUM, D_MIN);
      5'd15:   o = mk(K_CHAR, CH_COLON);
      5'd17:   o = mk(K_NUM, D_SEC);
      5'd19:   o = mk(K_GMT, 8'd0);
      5'd0, 5'd2, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd18:
               o = mk(K_BLANKS, 8'd0);
      default: o = mk(K_END, 8'd0);
    endcase
    return o;
  endfunction

  function automatic op_t op_asctime(logic [4:0] i);
    op_t o;
    case (i)
      5'd1:    o = mk(K_MONTH, 8'd0);
      5'd2:    o = mk(K_SKIP, 8'd0);
      5'd4:    o = mk(K_NUM, D_DAY);
      5'd5:    o = mk(K_SKIP, 8'd0);
      5'd7:    o = mk(K_NUM, D_HOUR);
      5'd9:    o = mk(K_CHAR, CH_COLON);
      5'd11:   o = mk(K_NUM, D_MIN);
      5'd13:   o = mk(K_CHAR, CH_COLON);
      5'd15:   o = mk(K_NUM, D_SEC);
      5'd16:   o = mk(K_SKIP, 8'd0);
      5'd18:   o = mk(K_NUM, D_YEAR);
      5'd0, 5'd3, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14, 5'd17:
               o = mk(K_BLANKS, 8'd0);
      default: o = mk(K_END, 8'd0);
    endcase
    return o;
  endfunction

  // operation at a phase; phase zero is the weekday name
  function automatic op_t cur_op(logic [PH_W-1:0] ph, logic [1:0] fmt);
    op_t        o;
    logic [4:0] idx;
    idx = ph - 5'd1;
    if (ph == '0 || ph > PH_W'(NUM_OPS)) begin
      o = mk(K_END, 8'd0);
    end else begin
      case (fmt)
        FMT_RFC1123: o = op_rfc1123(idx);
        FMT_RFC850:  o = op_rfc850(idx);
        FMT_ASCTIME: o = op_asctime(idx);
        default:     o = mk(K_END, 8'd0);
      endcase
    end
    return o;
  endfunction

  function automatic logic [PH_W-1:0] adv(logic [PH_W-1:0] ph);
    return (ph < PH_W'(NUM_OPS)) ? ph + PH_W'(1) : ph;
  endfunction

  function automatic logic [3:0] day_len(logic [3:0] i);
    logic [3:0] l;
    case (i)
      4'd5:                   l = 4'd7;
      4'd7:                   l = 4'd9;
      4'd9, 4'd13:            l = 4'd8;
      4'd1, 4'd3, 4'd11:      l = 4'd6;
      default:                l = 4'd3;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] day_char(logic [3:0] i, logic [3:0] n);
    logic [79:0] nm;
    case (i)
      4'd0:    nm = "sun       ";
      4'd1:    nm = "sunday    ";
      4'd2:    nm = "mon       ";
      4'd3:    nm = "monday    ";
      4'd4:    nm = "tue       ";
      4'd5:    nm = "tuesday   ";
      4'd6:    nm = "wed       ";
      4'd7:    nm = "wednesday ";
      4'd8:    nm = "thu       ";
      4'd9:    nm = "thursday  ";
      4'd10:   nm = "fri       ";
      4'd11:   nm = "friday    ";
      4'd12:   nm = "sat       ";
      default: nm = "saturday  ";
    endcase
    return (n > 4'd9) ? 8'd0 : nm[7'd79 - {n, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] mon_char(logic [3:0] i, logic [1:0] n);
    logic [23:0] nm;
    case (i)
      4'd0:    nm = "jan";
      4'd1:    nm = "feb";
      4'd2:    nm = "mar";
      4'd3:    nm = "apr";
      4'd4:    nm = "may";
      4'd5:    nm = "jun";
      4'd6:    nm = "jul";
      4'd7:    nm = "aug";
      4'd8:    nm = "sep";
      4'd9:    nm = "oct";
      4'd10:   nm = "nov";
      default: nm = "dec";
    endcase
    return (n == 2'd3) ? 8'd0 : nm[5'd23 - {n, 3'b000} -: 8];
  endfunction

  function automatic logic [7:0] gmt_char(logic [1:0] n);
    logic [23:0] nm;
    nm = "gmt";
    return (n == 2'd3) ? 8'd0 : nm[5'd23 - {n, 3'b000} -: 8];
  endfunction

endpackage

// ===== rtl/hdp_front.sv =====
// ----------------------------------------------------------------------------
// hdp_front
// Byte parser: tracks the format, names and numbers, emits one record per
// string on its last byte.
// ----------------------------------------------------------------------------
module hdp_front import hdp_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  output logic       rec_push_o,
  output date_rec_t  rec_o
);

  localparam int unsigned DC_W = $clog2(MAX_DIGITS + 1);

  logic [PH_W-1:0] ph_q, ph_d;
  logic [13:0]     wk_q, wk_d;
  logic [11:0]     mo_q, mo_d;
  logic [3:0]      nml_q, nml_d;
  logic [16:0]     acc_q, acc_d;
  logic [DC_W-1:0] dc_q, dc_d;
  logic [4:0]      day_q, day_d;
  logic [3:0]      mon_q, mon_d;
  logic [13:0]     yr_q, yr_d;
  logic [16:0]     sod_q, sod_d;
  logic [1:0]      fmt_q, fmt_d;
  logic            err_q, err_d;

  logic [7:0] lc;
  logic       blank;
  logic       digit;

  assign lc    = (char_byte_i inside {[8'h41:8'h5A]}) ? char_byte_i + 8'd32 : char_byte_i;
  assign blank = (char_byte_i == CH_SPACE) || (char_byte_i == CH_TAB);
  assign digit = char_byte_i inside {[8'h30:8'h39]};

  always_comb begin
    op_t         op;
    logic [13:0] wext;
    logic [11:0] mext;
    logic [3:0]  found;
    logic        fvalid;
    logic        stop;
    logic        fin_store;
    logic [20:0] prod;
    logic [16:0] v;
    logic [3:0]  mfirst;

    ph_d = ph_q;  wk_d = wk_q;  mo_d = mo_q;  nml_d = nml_q;
    acc_d = acc_q; dc_d = dc_q; day_d = day_q; mon_d = mon_q;
    yr_d = yr_q;  sod_d = sod_q; fmt_d = fmt_q; err_d = err_q;
    op = mk(K_END, 8'd0);
    wext = '0; mext = '0; found = '0; fvalid = 1'b0; stop = 1'b0;
    fin_store = 1'b0; prod = '0; v = '0; mfirst = '0;
    rec_push_o = 1'b0;
    rec_o = '0;

    if (take_i && !err_q) begin
      if (ph_q == '0) begin
        stop = 1'b1;
        if (!(nml_q == 4'd0 && blank)) begin
          for (int i = 0; i < NUM_DAYS; i++) begin
            if (wk_q[i] && nml_q < day_len(4'(i)) && day_char(4'(i), nml_q) == lc) begin
              wext[i] = 1'b1;
            end
          end
          if (wext != '0) begin
            wk_d  = wext;
            nml_d = nml_q + 4'd1;
          end else begin
            for (int i = 0; i < NUM_DAYS; i++) begin
              if (wk_q[i] && nml_q != 4'd0 && day_len(4'(i)) == nml_q) begin
                found  = 4'(i);
                fvalid = 1'b1;
              end
            end
            if (!fvalid) begin
              err_d = 1'b1;
            end else begin
              nml_d = '0;
              wk_d  = '1;
              ph_d  = PH_W'(1);
              // long name, or short name with blank, goes on in this byte
              if (found[0]) begin
                fmt_d = FMT_RFC850;
                stop  = 1'b0;
              end else if (blank) begin
                fmt_d = FMT_ASCTIME;
                stop  = 1'b0;
              end else begin
                fmt_d = FMT_RFC1123;
              end
            end
          end
        end
      end

      // a byte can close a number, pass one blank run and hit one more op
      for (int s = 0; s < 3; s++) begin
        if (!stop && !err_d) begin
          op = cur_op(ph_d, fmt_d);
          case (op.kind)
            K_END: stop = 1'b1;
            K_BLANKS: begin
              if (blank) stop = 1'b1;
              else ph_d = adv(ph_d);
            end
            K_SKIP: begin
              ph_d = adv(ph_d);
              stop = 1'b1;
            end
            K_CHAR: begin
              if (char_byte_i == op.arg) ph_d = adv(ph_d);
              else err_d = 1'b1;
              stop = 1'b1;
            end
            K_NUM: begin
              if (digit) begin
                if (32'(dc_d) >= MAX_DIGITS) begin
                  err_d = 1'b1;
                end else begin
                  prod  = {4'b0, acc_d} * 21'd10 + {17'b0, char_byte_i[3:0]};
                  acc_d = (prod > {4'b0, NUM_SAT}) ? NUM_SAT : prod[16:0];
                  dc_d  = dc_d + DC_W'(1);
                end
                stop = 1'b1;
              end else if (dc_d == '0) begin
                err_d = 1'b1;
                stop  = 1'b1;
              end else begin
                v = acc_d;
                case (op.arg)
                  D_DAY:  if (v < 17'd1 || v > 17'd31) err_d = 1'b1; else day_d = v[4:0];
                  D_YEAR: if (v > 17'd9999) err_d = 1'b1; else yr_d = v[13:0];
                  D_Y850: if (v > 17'd99) err_d = 1'b1; else yr_d = 14'd1900 + v[13:0];
                  D_HOUR: if (v >= 17'd24) err_d = 1'b1;
                          else sod_d = {12'b0, v[4:0]} * 17'd3600;
                  D_MIN:  if (v >= 17'd60) err_d = 1'b1;
                          else sod_d = sod_d + {11'b0, v[5:0]} * 17'd60;
                  default: if (v >= 17'd60) err_d = 1'b1;
                           else sod_d = sod_d + v;
                endcase
                acc_d = '0;
                dc_d  = '0;
                ph_d  = adv(ph_d);
              end
            end
            K_MONTH: begin
              stop = 1'b1;
              if (nml_d >= 4'd3) begin
                err_d = 1'b1;
              end else begin
                for (int i = 0; i < NUM_MONS; i++) begin
                  if (mo_d[i] && mon_char(4'(i), nml_d[1:0]) == lc) mext[i] = 1'b1;
                end
                if (mext == '0) begin
                  err_d = 1'b1;
                end else begin
                  mo_d  = mext;
                  nml_d = nml_d + 4'd1;
                  if (nml_d == 4'd3) begin
                    for (int i = NUM_MONS - 1; i >= 0; i--) begin
                      if (mext[i]) mfirst = 4'(i);
                    end
                    mon_d = mfirst + 4'd1;
                    nml_d = '0;
                    mo_d  = '1;
                    ph_d  = adv(ph_d);
                  end
                end
              end
            end
            default: begin
              stop = 1'b1;
              if (nml_d < 4'd3 && gmt_char(nml_d[1:0]) == lc) begin
                nml_d = nml_d + 4'd1;
                if (nml_d == 4'd3) begin
                  nml_d = '0;
                  ph_d  = adv(ph_d);
                end
              end else begin
                err_d = 1'b1;
              end
            end
          endcase
        end
      end
    end

    if (take_i && last_byte_i) begin
      // end of string closes a pending number and trailing blank runs
      if (!err_d && ph_d != '0) begin
        op = cur_op(ph_d, fmt_d);
        fin_store = (op.kind == K_NUM) && (dc_d != '0);
        if (fin_store) begin
          v = acc_d;
          case (op.arg)
            D_DAY:  if (v < 17'd1 || v > 17'd31) err_d = 1'b1; else day_d = v[4:0];
            D_YEAR: if (v > 17'd9999) err_d = 1'b1; else yr_d = v[13:0];
            D_Y850: if (v > 17'd99) err_d = 1'b1; else yr_d = 14'd1900 + v[13:0];
            D_HOUR: if (v >= 17'd24) err_d = 1'b1;
                    else sod_d = {12'b0, v[4:0]} * 17'd3600;
            D_MIN:  if (v >= 17'd60) err_d = 1'b1;
                    else sod_d = sod_d + {11'b0, v[5:0]} * 17'd60;
            default: if (v >= 17'd60) err_d = 1'b1;
                     else sod_d = sod_d + v;
          endcase
          ph_d = adv(ph_d);
        end
        for (int s = 0; s < 2; s++) begin
          if (cur_op(ph_d, fmt_d).kind == K_BLANKS) ph_d = adv(ph_d);
        end
      end
      rec_push_o  = 1'b1;
      rec_o.err   = err_d || ph_d == '0 || cur_op(ph_d, fmt_d).kind != K_END;
      rec_o.fmt   = fmt_d;
      rec_o.year  = yr_d;
      rec_o.month = mon_d;
      rec_o.day   = day_d;
      rec_o.sod   = sod_d;
      ph_d = '0;  wk_d = '1;  mo_d = '1;  nml_d = '0;
      acc_d = '0; dc_d = '0;  day_d = '0; mon_d = '0;
      yr_d = '0;  sod_d = '0; fmt_d = FMT_RFC1123; err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= '0;
      wk_q  <= '1;
      mo_q  <= '1;
      nml_q <= '0;
      acc_q <= '0;
      dc_q  <= '0;
      day_q <= '0;
      mon_q <= '0;
      yr_q  <= '0;
      sod_q <= '0;
      fmt_q <= FMT_RFC1123;
      err_q <= 1'b0;
    end else if (take_i) begin
      ph_q  <= ph_d;
      wk_q  <= wk_d;
      mo_q  <= mo_d;
      nml_q <= nml_d;
      acc_q <= acc_d;
      dc_q  <= dc_d;
      day_q <= day_d;
      mon_q <= mon_d;
      yr_q  <= yr_d;
      sod_q <= sod_d;
      fmt_q <= fmt_d;
      err_q <= err_d;
    end
  end

  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && last_byte_i |=> ph_q == '0 && !err_q && nml_q == 4'd0)
    else $error("parser state not cleared after last byte");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(dc_q) <= MAX_DIGITS)
    else $error("digit count beyond limit");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q <= PH_W'(NUM_OPS) && nml_q <= 4'd9)
    else $error("parser phase or name length out of range");

endmodule

// ===== rtl/hdp_queue.sv =====
// ----------------------------------------------------------------------------
// hdp_queue
// Two-entry queue of parsed records between parser and epoch unit.
// ----------------------------------------------------------------------------
module hdp_queue import hdp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  date_rec_t data_i,
  output logic      full_o,
  input  logic      pop_i,
  output date_rec_t data_o,
  output logic      empty_o
);

  date_rec_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/hdp_epoch.sv =====
// ----------------------------------------------------------------------------
// hdp_epoch
// Six-stage pipeline turning a parsed date into Unix epoch seconds; the last
// stage is the result register.
// ----------------------------------------------------------------------------
module hdp_epoch import hdp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rec_valid_i,
  input  date_rec_t          rec_i,
  output logic               rec_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [38:0] epoch_seconds_o,
  output logic               parse_error_o,
  output logic [1:0]         date_format_o
);

  // days before the first of each month, counting from march
  function automatic logic [8:0] cum_days(logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      default: d = 9'd337;
    endcase
    return d;
  endfunction

  logic [5:0] v_q;
  logic       en;

  logic        err_q [5];
  logic [1:0]  fmt_q [5];
  logic [16:0] sod_q [5];

  logic [13:0]        yy1_q, yy2_q;
  logic [8:0]         doy1_q, doy2_q, doy3_q;
  logic [26:0]        eprod_q;
  logic [4:0]         era3_q, era4_q;
  logic [8:0]         yoe3_q;
  logic [17:0]        doe4_q;
  logic signed [22:0] days5_q;

  logic signed [38:0] secs_q;
  logic               perr_q;
  logic [1:0]         pfmt_q;

  logic [3:0]         mp;
  logic [4:0]         era;
  logic signed [38:0] days_ext;

  assign en        = !v_q[5] || pop_i;
  assign rec_pop_o = en && rec_valid_i;
  assign mp        = (rec_i.month >= 4'd3) ? rec_i.month - 4'd3 : rec_i.month + 4'd9;
  assign era       = eprod_q[25:21];
  assign days_ext  = 39'(days5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], rec_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q[0] <= rec_i.err;
      fmt_q[0] <= rec_i.fmt;
      sod_q[0] <= rec_i.sod;
      for (int i = 1; i < 5; i++) begin
        err_q[i] <= err_q[i-1];
        fmt_q[i] <= fmt_q[i-1];
        sod_q[i] <= sod_q[i-1];
      end
      // march-based year shifted by one era so it stays positive
      yy1_q   <= rec_i.year + 14'd400 - {13'b0, rec_i.month <= 4'd2};
      doy1_q  <= cum_days(mp) + {4'b0, rec_i.day} - 9'd1;
      // division by 400 as reciprocal multiply
      eprod_q <= {13'b0, yy1_q} * 27'd5243;
      yy2_q   <= yy1_q;
      doy2_q  <= doy1_q;
      era3_q  <= era;
      yoe3_q  <= 9'(yy2_q - {9'b0, era} * 14'd400);
      doy3_q  <= doy2_q;
      era4_q  <= era3_q;
      doe4_q  <= {9'b0, yoe3_q} * 18'd365 + {11'b0, yoe3_q[8:2]}
                 - 18'(({9'b0, yoe3_q} * 18'd41) >> 12) + {9'b0, doy3_q};
      days5_q <= 23'({18'b0, era4_q} * 23'd146097) + {5'b0, doe4_q} - 23'd865565;
      secs_q  <= err_q[4] ? '0 : days_ext * 39'sd86400 + $signed({22'b0, sod_q[4]});
      perr_q  <= err_q[4];
      pfmt_q  <= fmt_q[4];
    end
  end

  assign empty_o         = !v_q[5];
  assign epoch_seconds_o = secs_q;
  assign parse_error_o   = perr_q;
  assign date_format_o   = pfmt_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] && parse_error_o |-> epoch_seconds_o == '0)
    else $error("rejected string carries nonzero seconds");

  a_fmt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[5] |-> date_format_o != 2'd3)
    else $error("unknown format code on result");

  a_take_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o |=> v_q[0])
    else $error("record taken from queue but not in pipeline");

endmodule

// ===== rtl/http_date_parser.sv =====
// ----------------------------------------------------------------------------
// http_date_parser
// Streaming HTTP date parser (RFC 1123, RFC 850, asctime) to epoch seconds.
// ----------------------------------------------------------------------------
// Accepts one byte of the date string per clock with no gaps required. Each
// byte only steps the parser state, so the input side sustains one transfer
// per cycle; full rises only when the two-entry record queue is full and the
// result side is stalled. The record for a string enters the queue on the
// edge that transfers its last byte, then passes a six-stage epoch pipeline
// (constant multiplies for the era, day of era, and days times 86400) whose
// final stage is the result register.
module http_date_parser import hdp_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_byte_i,
  input  logic               last_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [38:0] epoch_seconds_o,
  output logic               parse_error_o,
  output logic [1:0]         date_format_o
);

  logic      take;
  logic      rec_push, rec_pop, q_empty;
  date_rec_t rec_in, rec_out;

  assign take = push && !full;

  hdp_front #(.MAX_DIGITS(MAX_DIGITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_byte_i (char_byte_i),
    .last_byte_i (last_byte_i),
    .rec_push_o  (rec_push),
    .rec_o       (rec_in)
  );

  hdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .data_o  (rec_out),
    .empty_o (q_empty)
  );

  hdp_epoch u_epoch (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (!q_empty),
    .rec_i           (rec_out),
    .rec_pop_o       (rec_pop),
    .empty_o         (empty),
    .pop_i           (pop),
    .epoch_seconds_o (epoch_seconds_o),
    .parse_error_o   (parse_error_o),
    .date_format_o   (date_format_o)
  );

endmodule

// ===== bench/date_checker.sv =====
// ----------------------------------------------------------------------------
// date_checker
// Watches both queue sides of the HTTP date parser, computes the expected
// epoch result of every string from its transferred bytes, and compares.
// ----------------------------------------------------------------------------
module date_checker import hdp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic [7:0]         char_byte_i,
  input  logic               last_byte_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic signed [38:0] epoch_seconds_i,
  input  logic               parse_error_i,
  input  logic [1:0]         date_format_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 good_dates_o,
  output int                 rejected_dates_o
);

  localparam int DIGIT_LIMIT = 5;

  typedef struct {
    logic signed [38:0] epoch;
    logic               err;
    logic [1:0]         fmt;
  } date_result_t;

  date_result_t date_results_q[$];

  string weekday_names[14] = '{"sun", "sunday", "mon", "monday", "tue", "tuesday",
    "wed", "wednesday", "thu", "thursday", "fri", "friday", "sat", "saturday"};
  string month_names[12] = '{"jan", "feb", "mar", "apr", "may", "jun", "jul", "aug",
    "sep", "oct", "nov", "dec"};

  // per format: step kinds and their argument (destination digit or literal)
  string kinds_by_fmt[3] = '{"BNBMBNBNBCBNBCBNBG", "BCBNCMCNBNBCBNBCBNBG",
                             "BMSBNSBNBCBNBCBNSBN"};
  string args_by_fmt[3]  = '{"-0---1-3-:-4-:-5--", "-,-0---2-3-:-4-:-5--",
                             "----0--3-:-4-:-5--1"};

  int       phase, wd_mask, mo_mask, match_len, accum, digits;
  int       day_v, month_v, year_v, sod_v, fmt_v;
  bit       err_v;

  function automatic void clear_parser();
    phase = 0; wd_mask = 'h3FFF; mo_mask = 'hFFF; match_len = 0; accum = 0;
    digits = 0; day_v = 0; month_v = 0; year_v = 0; sod_v = 0; fmt_v = 0;
    err_v = 0;
  endfunction

  function automatic byte step_kind();
    if (phase == 0 || phase - 1 >= kinds_by_fmt[fmt_v].len()) return "E";
    return kinds_by_fmt[fmt_v][phase-1];
  endfunction

  function automatic byte step_arg();
    return args_by_fmt[fmt_v][phase-1];
  endfunction

  function automatic void next_step();
    if (phase < 24) phase++;
  endfunction

  function automatic void store_field(byte dest);
    case (dest)
      "0": if (accum < 1 || accum > 31) err_v = 1; else day_v = accum;
      "1": if (accum > 9999) err_v = 1; else year_v = accum;
      "2": if (accum > 99) err_v = 1; else year_v = 1900 + accum;
      "3": if (accum >= 24) err_v = 1; else sod_v = accum * 3600;
      "4": if (accum >= 60) err_v = 1; else sod_v += accum * 60;
      default: if (accum >= 60) err_v = 1; else sod_v += accum;
    endcase
    accum = 0;
    digits = 0;
  endfunction

  function automatic void run_steps(byte c, byte lc, bit blank);
    byte k;
    int  hits;
    for (int g = 0; g < 32 && !err_v; g++) begin
      k = step_kind();
      case (k)
        "E": return;
        "B": begin
          if (blank) return;
          next_step();
        end
        "S": begin
          next_step();
          return;
        end
        "C": begin
          if (c == step_arg()) next_step(); else err_v = 1;
          return;
        end
        "N": begin
          if (c >= "0" && c <= "9") begin
            if (digits >= DIGIT_LIMIT) err_v = 1;
            else begin
              accum = accum * 10 + (c - "0");
              if (accum > NUM_SAT) accum = NUM_SAT;
              digits++;
            end
            return;
          end
          if (digits == 0) begin
            err_v = 1;
            return;
          end
          store_field(step_arg());
          next_step();
        end
        "M": begin
          hits = 0;
          if (match_len >= 3) begin
            err_v = 1;
            return;
          end
          for (int i = 0; i < 12; i++)
            if (mo_mask[i] && month_names[i][match_len] == lc) hits |= 1 << i;
          if (hits == 0) begin
            err_v = 1;
            return;
          end
          mo_mask = hits;
          match_len++;
          if (match_len == 3) begin
            for (int i = 11; i >= 0; i--) if (hits[i]) month_v = i + 1;
            match_len = 0;
            mo_mask = 'hFFF;
            next_step();
          end
          return;
        end
        default: begin
          string gmt = "gmt";
          if (match_len < 3 && gmt[match_len] == lc) begin
            match_len++;
            if (match_len == 3) begin
              match_len = 0;
              next_step();
            end
          end else err_v = 1;
          return;
        end
      endcase
    end
  endfunction

  function automatic void take_char(byte c);
    byte lc;
    bit  blank;
    int  hits, found;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    blank = (c == CH_SPACE || c == CH_TAB);
    if (phase == 0) begin
      hits = 0;
      found = 14;
      if (match_len == 0 && blank) return;
      for (int i = 0; i < 14; i++)
        if (wd_mask[i] && match_len < weekday_names[i].len() &&
            weekday_names[i][match_len] == lc) hits |= 1 << i;
      if (hits != 0) begin
        wd_mask = hits;
        match_len++;
        return;
      end
      for (int i = 0; i < 14; i++)
        if (wd_mask[i] && match_len > 0 && weekday_names[i].len() == match_len) found = i;
      if (found >= 14) begin
        err_v = 1;
        return;
      end
      match_len = 0;
      wd_mask = 'h3FFF;
      phase = 1;
      if (found % 2 == 1) fmt_v = FMT_RFC850;
      else if (blank) fmt_v = FMT_ASCTIME;
      else begin
        fmt_v = FMT_RFC1123;
        return;
      end
    end
    run_steps(c, lc, blank);
  endfunction

  function automatic longint civil_to_days(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = y + 400 - (m <= 2 ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468 - 146097;
  endfunction

  function automatic void date_byte(byte c, bit last);
    date_result_t r;
    longint secs;
    if (!err_v) take_char(c);
    if (!last) return;
    if (!err_v && phase != 0) begin
      if (step_kind() == "N" && digits > 0) begin
        store_field(step_arg());
        next_step();
      end
      for (int g = 0; g < 32 && step_kind() == "B"; g++) next_step();
    end
    r.fmt = fmt_v[1:0];
    if (!err_v && phase != 0 && step_kind() == "E") begin
      secs = civil_to_days(year_v, month_v, day_v) * 86400 + sod_v;
      r.epoch = secs[38:0];
      r.err = 0;
    end else begin
      r.epoch = '0;
      r.err = 1;
    end
    date_results_q.push_back(r);
    clear_parser();
  endfunction

  assign pending_o = date_results_q.size();

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_parser();
    end else begin
      if (push_i && !full_i) date_byte(char_byte_i, last_byte_i);
      if (pop_i && !empty_i) begin
        if (date_results_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result transfer at %0t", $time);
        end else begin
          date_result_t e;
          e = date_results_q.pop_front();
          if (e.err) rejected_dates_o++; else good_dates_o++;
          if (e.epoch !== epoch_seconds_i || e.err !== parse_error_i ||
              e.fmt !== date_format_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch at %0t: exp epoch %0d err %0d fmt %0d, got %0d %0d %0d",
                       $time, e.epoch, e.err, e.fmt, epoch_seconds_i, parse_error_i,
                       date_format_i);
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_http_date_parser.sv =====
// ----------------------------------------------------------------------------
// tb_http_date_parser
// Feeds HTTP date strings of all three formats, broken strings and noise
// byte by byte, with random gaps and stalls; a checker compares results.
// ----------------------------------------------------------------------------
module tb_http_date_parser import hdp_pkg::*;;

  logic               clk_i = 0;
  logic               rst_ni;
  logic               push, full, empty, pop;
  logic [7:0]         char_byte_i;
  logic               last_byte_i;
  logic signed [38:0] epoch_seconds_o;
  logic               parse_error_o;
  logic [1:0]         date_format_o;
  int                 fail_count, pending, good_dates, rejected_dates;
  int                 idle_pct, stall_pct, bytes_sent, strings_sent;

  string short_days[7] = '{"sun", "mon", "tue", "wed", "thu", "fri", "sat"};
  string long_days[7]  = '{"sunday", "monday", "tuesday", "wednesday", "thursday",
                           "friday", "saturday"};
  string months[12] = '{"jan", "feb", "mar", "apr", "may", "jun", "jul", "aug",
                        "sep", "oct", "nov", "dec"};

  http_date_parser u_top (
    .clk_i, .rst_ni, .push, .full, .char_byte_i, .last_byte_i,
    .empty, .pop, .epoch_seconds_o, .parse_error_o, .date_format_o
  );

  date_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .char_byte_i, .last_byte_i,
    .empty_i(empty), .pop_i(pop), .epoch_seconds_i(epoch_seconds_o),
    .parse_error_i(parse_error_o), .date_format_i(date_format_o),
    .fail_count_o(fail_count), .pending_o(pending), .good_dates_o(good_dates),
    .rejected_dates_o(rejected_dates)
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic string mixed_case(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
    return r;
  endfunction

  function automatic string blanks();
    case ($urandom_range(5))
      0: return "";
      1: return "\t";
      2: return "  ";
      default: return " ";
    endcase
  endfunction

  // mostly in range, sometimes beyond
  function automatic int field(int lo, int hi);
    if ($urandom_range(9) == 0) return $urandom_range(999);
    if ($urandom_range(49) == 0) return 100000 + $urandom_range(99999);
    return $urandom_range(hi, lo);
  endfunction

  function automatic string random_date();
    string s, wd, mo, tail;
    int    d;
    d  = $urandom_range(6);
    mo = mixed_case(months[$urandom_range(11)]);
    tail = ($urandom_range(4) == 0) ? " trailing" : "";
    case ($urandom_range(2))
      0: s = $sformatf("%s%s,%s%02d%s%s%s%04d%s%02d%s:%s%02d:%02d%sGMT%s", blanks(),
                       mixed_case(short_days[d]), blanks(), field(1, 31), blanks(), mo,
                       blanks(), field(0, 9999), blanks(), field(0, 23), blanks(),
                       blanks(), field(0, 59), field(0, 59), blanks(), tail);
      1: s = $sformatf("%s%s,%s%02d-%s-%02d %02d:%02d%s:%02d %s%s", blanks(),
                       mixed_case(long_days[d]), blanks(), field(1, 31), mo,
                       field(0, 99), field(0, 23), field(0, 59), blanks(), field(0, 59),
                       mixed_case("gmt"), tail);
      default: s = $sformatf("%s%s%s%s %2d %02d:%02d:%02d%s%04d%s",
                             mixed_case(short_days[d]), ($urandom_range(1) ? " " : "\t"),
                             mo, blanks(), field(1, 31), field(0, 23), field(0, 59),
                             field(0, 59), ($urandom_range(1) ? " " : "  "),
                             field(1970, 2100), tail);
    endcase
    // occasional corruption or truncation
    case ($urandom_range(9))
      0: s[$urandom_range(s.len() - 1)] = $urandom_range(255);
      1: s = s.substr(0, $urandom_range(s.len() - 1));
      default: ;
    endcase
    return s;
  endfunction

  function automatic string noise();
    string s;
    s = "x";
    for (int i = $urandom_range(7); i > 0; i--) s = {s, "x"};
    for (int i = 0; i < s.len(); i++) s[i] = $urandom_range(255, 1);
    return s;
  endfunction

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        push <= 0;
        @(posedge clk_i);
      end
      push <= 1;
      char_byte_i <= s[i];
      last_byte_i <= (i == s.len() - 1);
      @(posedge clk_i);
      while (full) @(posedge clk_i);
      bytes_sent++;
    end
    strings_sent++;
  endtask

  task automatic set_phase(int n);
    case ((n / 9) % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 54; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 54; end
      default: begin idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  string directed[$] = '{
    "Sun, 06 Nov 1994 08:49:37 GMT",
    "Sunday, 06-Nov-94 08:49:37 GMT",
    "Sun Nov  6 08:49:37 1994",
    "  SAT,01 JAN 0000 00:00:00 gmt",
    "Fri, 31 Dec 9999 23:59:59 GMT extra",
    "Wednesday, 31-dec-99 23:59:59 GMT",
    "thursday, 01-Jan-00 00:00:00 GMT",
    "Mon\tFeb 29 12:00:00 2000",
    "Tue Mar 1 00:00:00 9",
    "Wed Apr  1 10:10:10 2020 zzz",
    "Xyz, 06 Nov 1994 08:49:37 GMT",
    "Sund, 06 Nov 1994 08:49:37 GMT",
    "Sun, Nov 1994 08:49:37 GMT",
    "Sun, 123456 Nov 1994 08:49:37 GMT",
    "Sun, 00 Nov 1994 08:49:37 GMT",
    "Sun, 32 Nov 1994 08:49:37 GMT",
    "Sun, 06 Nov 1994 24:00:00 GMT",
    "Sun, 06 Nov 1994 23:60:00 GMT",
    "Sunday, 06-Nov-94 08:49:60 GMT",
    "Sunday, 06-Nov-194 08:49:37 GMT",
    "Sun, 06 Nov 10000 08:49:37 GMT",
    "Sun, 06 Nov 1994 08:49:37 UTC",
    "Sun, 06 Nov 1994 08:49",
    "Sun Xov  6 08:49:37 1994",
    "\377"
  };

  initial begin
    rst_ni = 0;
    push <= 0;
    char_byte_i <= '0;
    last_byte_i <= 0;
    idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    strings_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      set_phase(strings_sent);
      send_string(directed[i]);
    end
    while (bytes_sent < 950) begin
      set_phase(strings_sent);
      if ($urandom_range(9) == 0) send_string(noise());
      else send_string(random_date());
    end
    push <= 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("%0d strings in %0d bytes: %0d dates decoded, %0d rejected",
             strings_sent, bytes_sent, good_dates, rejected_dates);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
